// ----- rtl/fcw_pkg.sv -----
package fcw_pkg;

    localparam int TABLE_BYTES_DEF = 131072;

    localparam int CLU_W      = 28;
    localparam int HOP_W      = 20;
    localparam int LADDR_W    = 17;
    localparam int BYTE_W     = 8;
    localparam int SPC_W      = 8;
    localparam int FDS_W      = 32;
    localparam int PSTART_W   = 48;
    localparam int SEC_W      = 49;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CLU_W-1:0] EOC_FAT12 = CLU_W'(28'hff8);
    localparam logic [CLU_W-1:0] EOC_FAT16 = CLU_W'(28'hfff8);
    localparam logic [CLU_W-1:0] EOC_FAT32 = CLU_W'(28'hffffff8);
    localparam logic [15:0]      MASK_FAT12 = 16'hfff;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_WALK = 1'b1
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_FAT12 = 2'd0,
        KIND_FAT16 = 2'd1,
        KIND_FAT32 = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAT_KIND    = 2'd0,
        CFG_SPC         = 2'd1,
        CFG_FIRST_DATA  = 2'd2,
        CFG_PART_START  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_FETCH,
        BS_CHECK,
        BS_MUL,
        BS_SUM
    } t_bstate;

    // queued work: arg is the start cluster of a walk or the byte address of a load
    typedef struct packed {
        t_op                op;
        logic [CLU_W-1:0]   arg;
        logic [HOP_W-1:0]   hops;
        logic [BYTE_W-1:0]  data;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SPC_W-1:0]   spc;
        logic [SEC_W-1:0]   base;
    } t_cfg;

endpackage

// ----- rtl/fcw_front.sv -----
module fcw_front
    import fcw_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic                i_op,
    input  logic [LADDR_W-1:0]  i_load_address,
    input  logic [BYTE_W-1:0]   i_load_byte,
    input  logic [CLU_W-1:0]    i_start_cluster,
    input  logic [HOP_W-1:0]    i_hop_count,
    output logic                o_q_valid,
    output t_item               o_q_item,
    input  logic                i_q_pop
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int EXT_W = 21;
    localparam logic [EXT_W-1:0] TB_EXT = EXT_W'(TABLE_BYTES);

    t_item              r_mem [DEPTH];
    logic [PW-1:0]      r_wp;
    logic [PW-1:0]      r_rp;
    logic [PW:0]        r_cnt;
    logic [PW-1:0]      n_wp;
    logic [PW-1:0]      n_rp;
    logic [PW:0]        n_cnt;

    t_item              item;
    logic               in_range;
    logic               enq;
    logic               deq;

    always_comb begin
        in_range = EXT_W'(i_load_address) < TB_EXT;
        item.op  = t_op'(i_op);
        if (t_op'(i_op) == OP_WALK) begin
            item.arg  = i_start_cluster;
            item.hops = i_hop_count;
            item.data = '0;
        end else begin
            item.arg  = CLU_W'(i_load_address);
            item.hops = '0;
            item.data = i_load_byte;
        end
    end

    // loads past the store are taken but dropped here
    assign full      = (r_cnt == (PW+1)'(DEPTH));
    assign enq       = push && !full && ((t_op'(i_op) == OP_WALK) || in_range);
    assign deq       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rp];

    always_comb begin
        n_wp  = enq ? r_wp + PW'(1) : r_wp;
        n_rp  = deq ? r_rp + PW'(1) : r_rp;
        n_cnt = r_cnt + (PW+1)'(enq) - (PW+1)'(deq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_mem[r_wp] <= item;
        end
    end

endmodule

// ----- rtl/fcw_table.sv -----
module fcw_table
    import fcw_pkg::*;
#(
    parameter int RW = 15
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [1:0]                  i_wbank,
    input  logic [RW-1:0]               i_wrow,
    input  logic [BYTE_W-1:0]           i_wdata,
    input  logic [3:0][RW-1:0]          i_rrow,
    output logic [3:0][BYTE_W-1:0]      o_rdata
);

    // four byte lanes so any four consecutive bytes come out in one read
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [BYTE_W-1:0] mem [2**RW];
        logic [BYTE_W-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_we && (i_wbank == 2'(b))) begin
                mem[i_wrow] <= i_wdata;
            end
            r_rd <= mem[i_rrow[b]];
        end

        assign o_rdata[b] = r_rd;
    end

endmodule

// ----- rtl/fcw_back.sv -----
module fcw_back
    import fcw_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_item               i_q_item,
    output logic                o_q_pop,
    input  t_cfg                i_cfg,
    output logic                empty,
    input  logic                pop,
    output logic [CLU_W-1:0]    o_cluster,
    output logic                o_reached_end,
    output logic [SEC_W-1:0]    o_sector_address
);

    localparam int AW    = $clog2(TABLE_BYTES);
    localparam int RW    = AW - 2;
    localparam int OFF_W = CLU_W + 2;
    localparam int PROD_W = SEC_W + SPC_W;
    localparam logic [OFF_W-1:0] TB_OFF = OFF_W'(TABLE_BYTES);

    t_bstate                r_state, n_state;
    logic [CLU_W-1:0]       r_clu, n_clu;
    logic [HOP_W-1:0]       r_hops, n_hops;
    logic                   r_ended, n_ended;
    logic [1:0]             r_lo;
    logic                   r_oor;
    logic [SEC_W-1:0]       r_prod;
    logic                   r_out_valid, n_out_valid;
    logic [CLU_W-1:0]       r_out_clu;
    logic                   r_out_end;
    logic [SEC_W-1:0]       r_out_sec;

    logic                   we;
    logic [3:0][RW-1:0]     rrow;
    logic [3:0][BYTE_W-1:0] rdata;

    logic [OFF_W-1:0]       off;
    logic [OFF_W-1:0]       last;
    logic                   oor;
    logic [RW-1:0]          row_base;

    logic [3:0][BYTE_W-1:0] byt;
    logic [15:0]            w16;
    logic [31:0]            w32;
    logic [CLU_W-1:0]       val;
    logic [CLU_W-1:0]       mark;
    logic                   stop;

    logic [SEC_W-1:0]       rel;
    logic [PROD_W-1:0]      prod;
    logic                   slot_free;
    logic                   out_load;

    fcw_table #(
        .RW (RW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_wbank (i_q_item.arg[1:0]),
        .i_wrow  (i_q_item.arg[AW-1:2]),
        .i_wdata (i_q_item.data),
        .i_rrow  (rrow),
        .o_rdata (rdata)
    );

    function automatic t_kind kind_sel();
        case (i_cfg.kind)
            KIND_FAT12: kind_sel = KIND_FAT12;
            KIND_FAT16: kind_sel = KIND_FAT16;
            default:    kind_sel = KIND_FAT32;
        endcase
    endfunction

    // entry address of the current cluster
    always_comb begin
        case (kind_sel())
            KIND_FAT12: begin
                off  = OFF_W'(r_clu) + OFF_W'(r_clu[CLU_W-1:1]);
                last = off + OFF_W'(1);
            end
            KIND_FAT16: begin
                off  = OFF_W'({r_clu, 1'b0});
                last = off + OFF_W'(1);
            end
            default: begin
                off  = {r_clu, 2'b00};
                last = off + OFF_W'(3);
            end
        endcase
        oor      = (last >= TB_OFF);
        row_base = off[AW-1:2];
        for (int b = 0; b < 4; b++) begin
            rrow[b] = (2'(b) < off[1:0]) ? row_base + RW'(1) : row_base;
        end
    end

    // entry decode on the registered read
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            byt[k] = rdata[r_lo + 2'(k)];
        end
        w16 = {byt[1], byt[0]};
        w32 = {byt[3], byt[2], byt[1], byt[0]};
        case (kind_sel())
            KIND_FAT12: begin
                val  = r_clu[0] ? CLU_W'(w16[15:4]) : CLU_W'(w16 & MASK_FAT12);
                mark = EOC_FAT12;
            end
            KIND_FAT16: begin
                val  = CLU_W'(w16);
                mark = EOC_FAT16;
            end
            default: begin
                val  = w32[CLU_W-1:0];
                mark = EOC_FAT32;
            end
        endcase
        stop = r_oor || (val == '0) || (val >= mark);
    end

    assign rel       = SEC_W'(r_clu) - SEC_W'(2);
    assign prod      = PROD_W'(rel) * PROD_W'(i_cfg.spc);
    assign slot_free = !r_out_valid || pop;

    always_comb begin
        n_state     = r_state;
        n_clu       = r_clu;
        n_hops      = r_hops;
        n_ended     = r_ended;
        o_q_pop     = 1'b0;
        we          = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.op == OP_LOAD) begin
                        we = 1'b1;
                    end else begin
                        n_clu   = i_q_item.arg;
                        n_hops  = i_q_item.hops;
                        n_ended = 1'b0;
                        n_state = (i_q_item.hops == '0) ? BS_MUL : BS_FETCH;
                    end
                end
            end
            BS_FETCH: begin
                n_state = BS_CHECK;
            end
            BS_CHECK: begin
                n_hops = r_hops - HOP_W'(1);
                if (stop) begin
                    n_ended = 1'b1;
                    n_state = BS_MUL;
                end else begin
                    n_clu   = val;
                    n_state = (r_hops == HOP_W'(1)) ? BS_MUL : BS_FETCH;
                end
            end
            BS_MUL: begin
                n_state = BS_SUM;
            end
            BS_SUM: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_state  = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
        n_out_valid = out_load ? 1'b1 : (pop ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clu   <= n_clu;
        r_hops  <= n_hops;
        r_ended <= n_ended;
        if (r_state == BS_FETCH) begin
            r_lo  <= off[1:0];
            r_oor <= oor;
        end
        if (r_state == BS_MUL) begin
            r_prod <= prod[SEC_W-1:0];
        end
        if (out_load) begin
            r_out_clu <= r_ended ? '0 : r_clu;
            r_out_end <= r_ended;
            r_out_sec <= r_ended ? '0 : r_prod + i_cfg.base;
        end
    end

    assign empty            = !r_out_valid;
    assign o_cluster        = r_out_clu;
    assign o_reached_end    = r_out_end;
    assign o_sector_address = r_out_sec;

endmodule

// ----- rtl/fat_cluster_chain_walker_top.sv -----
// channel  | handshake            | beat
// ---------+----------------------+-----------------------------------------------
// input    | push / full          | i_op, i_load_address, i_load_byte,
//          |                      | i_start_cluster, i_hop_count
// result   | empty / pop          | o_cluster, o_reached_end, o_sector_address
// config   | i_cfg_we             | i_cfg_index, i_cfg_data
//
// A load is written as it leaves the queue; loads stream at one beat a cycle
// while no walk is in progress. A walk passes a fetch and a check state per
// hop (one registered four-lane read per hop) until the hops run out or the
// chain ends, then a multiply and a sum state. A four-entry queue sits in front.
// Reset is synchronous; the table is not cleared and holds garbage until loaded.
// Either side may stall at any time; the input side keeps taking beats until
// the queue fills, even while a result waits on the output.
module fat_cluster_chain_walker_top
    import fcw_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_op,
    input  logic [LADDR_W-1:0]      i_load_address,
    input  logic [BYTE_W-1:0]       i_load_byte,
    input  logic [CLU_W-1:0]        i_start_cluster,
    input  logic [HOP_W-1:0]        i_hop_count,
    output logic                    empty,
    input  logic                    pop,
    output logic [CLU_W-1:0]        o_cluster,
    output logic                    o_reached_end,
    output logic [SEC_W-1:0]        o_sector_address,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic [KIND_W-1:0]      r_kind;
    logic [SPC_W-1:0]       r_spc;
    logic [FDS_W-1:0]       r_fds;
    logic [PSTART_W-1:0]    r_pstart;
    logic [SEC_W-1:0]       r_base;

    t_cfg                   cfg;
    logic                   q_valid;
    t_item                  q_item;
    logic                   q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= KIND_FAT16;
            r_spc    <= SPC_W'(1);
            r_fds    <= '0;
            r_pstart <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FAT_KIND:   r_kind   <= i_cfg_data[KIND_W-1:0];
                CFG_SPC:        r_spc    <= i_cfg_data[SPC_W-1:0];
                CFG_FIRST_DATA: r_fds    <= i_cfg_data[FDS_W-1:0];
                CFG_PART_START: r_pstart <= i_cfg_data[PSTART_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= SEC_W'(r_fds) + SEC_W'(r_pstart);
    end

    assign cfg.kind = r_kind;
    assign cfg.spc  = r_spc;
    assign cfg.base = r_base;

    fcw_front #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_op            (i_op),
        .i_load_address  (i_load_address),
        .i_load_byte     (i_load_byte),
        .i_start_cluster (i_start_cluster),
        .i_hop_count     (i_hop_count),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    fcw_back #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_item         (q_item),
        .o_q_pop          (q_pop),
        .i_cfg            (cfg),
        .empty            (empty),
        .pop              (pop),
        .o_cluster        (o_cluster),
        .o_reached_end    (o_reached_end),
        .o_sector_address (o_sector_address)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import fcw_pkg::*;

    localparam int TBL = TABLE_BYTES_DEF;
    localparam int HOLD_AT = 40;
    localparam int HOLD_LEN = 500;
    localparam logic [KIND_W-1:0] KIND_FAT32_ALT = 2'd3;

    typedef struct {
        t_op                op;
        logic [LADDR_W-1:0] addr;
        logic [BYTE_W-1:0]  data;
        logic [CLU_W-1:0]   start;
        logic [HOP_W-1:0]   hops;
    } t_fat_beat;

    typedef struct {
        logic [CLU_W-1:0] cluster;
        logic             end_hit;
        logic [SEC_W-1:0] sector;
    } t_link_result;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  i_op = 1'b0;
    logic [LADDR_W-1:0]    i_load_address = '0;
    logic [BYTE_W-1:0]     i_load_byte = '0;
    logic [CLU_W-1:0]      i_start_cluster = '0;
    logic [HOP_W-1:0]      i_hop_count = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [CLU_W-1:0]      o_cluster;
    logic                  o_reached_end;
    logic [SEC_W-1:0]      o_sector_address;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    fat_cluster_chain_walker_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_op             (i_op),
        .i_load_address   (i_load_address),
        .i_load_byte      (i_load_byte),
        .i_start_cluster  (i_start_cluster),
        .i_hop_count      (i_hop_count),
        .empty            (empty),
        .pop              (pop),
        .o_cluster        (o_cluster),
        .o_reached_end    (o_reached_end),
        .o_sector_address (o_sector_address),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // mirror follows accepted beats; draft follows queued beats
    bit [7:0] fat_mirror [TBL];
    bit [7:0] fat_draft [TBL];
    bit       fat_loaded [TBL];

    logic [KIND_W-1:0] cfg_kind = KIND_FAT16;
    logic [SPC_W-1:0]  cfg_spc = 8'd1;
    logic [FDS_W-1:0]  cfg_fds = '0;
    logic [PSTART_W-1:0] cfg_ps = '0;

    t_fat_beat    table_ops_q [$];
    t_link_result chain_results_q [$];
    int           beats_owed = 0;
    int           phase_beats = 0;
    int           fails = 0;
    int           results_seen = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [CLU_W-1:0] end_mark();
        if (cfg_kind == KIND_FAT12) return EOC_FAT12;
        if (cfg_kind == KIND_FAT16) return EOC_FAT16;
        return EOC_FAT32;
    endfunction

    function automatic logic [CLU_W-1:0] entry_max();
        if (cfg_kind == KIND_FAT12) return CLU_W'(MASK_FAT12);
        if (cfg_kind == KIND_FAT16) return CLU_W'(16'hffff);
        return {CLU_W{1'b1}};
    endfunction

    function automatic int unsigned top_cluster();
        if (cfg_kind == KIND_FAT12) return (2 * TBL - 4) / 3;
        if (cfg_kind == KIND_FAT16) return TBL / 2 - 1;
        return TBL / 4 - 1;
    endfunction

    // 0 when the entry lies past the store; blind marks a draft read of unloaded bytes
    function automatic bit read_link(input bit draft, input logic [CLU_W-1:0] c,
                                     output logic [CLU_W-1:0] link, output bit blind);
        logic [63:0] off;
        int unsigned nb;
        logic [31:0] word;
        int i;
        blind = 1'b0;
        link = '0;
        word = '0;
        if (cfg_kind == KIND_FAT12) begin
            off = 64'(c) + 64'(c >> 1);
            nb = 2;
        end else if (cfg_kind == KIND_FAT16) begin
            off = 64'(c) * 2;
            nb = 2;
        end else begin
            off = 64'(c) * 4;
            nb = 4;
        end
        if (off + nb - 1 >= TBL) return 1'b0;
        for (i = 0; i < nb; i++) begin
            word[8*i +: 8] = draft ? fat_draft[off + i] : fat_mirror[off + i];
            if (draft && !fat_loaded[off + i]) blind = 1'b1;
        end
        if (cfg_kind == KIND_FAT12)
            link = c[0] ? CLU_W'(word[15:4]) : CLU_W'(word[15:0] & MASK_FAT12);
        else if (cfg_kind == KIND_FAT16)
            link = CLU_W'(word[15:0]);
        else
            link = word[CLU_W-1:0];
        return 1'b1;
    endfunction

    function automatic void chase(input bit draft, input logic [CLU_W-1:0] start,
                                  input logic [HOP_W-1:0] hops,
                                  output logic [CLU_W-1:0] at, output bit ended,
                                  output int unsigned clean);
        logic [CLU_W-1:0] link;
        bit blind;
        int unsigned n;
        at = start;
        ended = 1'b0;
        clean = 32'(hops);
        for (n = 0; n < hops && !ended; n++) begin
            if (!read_link(draft, at, link, blind)) begin
                ended = 1'b1;
            end else if (blind) begin
                clean = n;
                break;
            end else if (link == '0 || link >= end_mark()) begin
                ended = 1'b1;
            end else begin
                at = link;
            end
        end
    endfunction

    function automatic t_link_result predict_walk(logic [CLU_W-1:0] start,
                                                  logic [HOP_W-1:0] hops);
        t_link_result r;
        logic [CLU_W-1:0] at;
        bit ended;
        int unsigned clean;
        chase(1'b0, start, hops, at, ended, clean);
        if (ended) begin
            r.cluster = '0;
            r.end_hit = 1'b1;
            r.sector = '0;
        end else begin
            r.cluster = at;
            r.end_hit = 1'b0;
            r.sector = (SEC_W'(at) - SEC_W'(2)) * SEC_W'(cfg_spc) + SEC_W'(cfg_fds)
                       + SEC_W'(cfg_ps);
        end
        return r;
    endfunction

    function automatic void queue_load(int unsigned addr, logic [7:0] b);
        t_fat_beat t;
        fat_draft[addr] = b;
        fat_loaded[addr] = 1'b1;
        t.op = OP_LOAD;
        t.addr = LADDR_W'(addr);
        t.data = b;
        t.start = CLU_W'($urandom);
        t.hops = HOP_W'($urandom);
        table_ops_q.push_back(t);
        beats_owed++;
        phase_beats++;
    endfunction

    // hops are cut short where the walk would read bytes never loaded
    function automatic void queue_walk(logic [CLU_W-1:0] start, logic [HOP_W-1:0] hops);
        t_fat_beat t;
        logic [CLU_W-1:0] at;
        bit ended;
        int unsigned clean;
        chase(1'b1, start, hops, at, ended, clean);
        if (clean < hops) hops = HOP_W'(clean);
        t.op = OP_WALK;
        t.addr = LADDR_W'($urandom);
        t.data = BYTE_W'($urandom);
        t.start = start;
        t.hops = hops;
        table_ops_q.push_back(t);
        beats_owed++;
        phase_beats++;
    endfunction

    function automatic void set_link(logic [CLU_W-1:0] c, logic [CLU_W-1:0] v);
        int unsigned off;
        logic [15:0] w;
        logic [31:0] word;
        if (cfg_kind == KIND_FAT12) begin
            off = 32'(c) + 32'(c >> 1);
            if (off + 1 >= TBL) return;
            w = {fat_draft[off + 1], fat_draft[off]};
            if (c[0]) w = {v[11:0], w[3:0]};
            else w = {w[15:12], v[11:0]};
            queue_load(off, w[7:0]);
            queue_load(off + 1, w[15:8]);
        end else if (cfg_kind == KIND_FAT16) begin
            off = 32'(c) * 2;
            if (off + 1 >= TBL) return;
            queue_load(off, v[7:0]);
            queue_load(off + 1, v[15:8]);
        end else begin
            off = 32'(c) * 4;
            if (off + 3 >= TBL) return;
            word = {4'($urandom), v};
            queue_load(off, word[7:0]);
            queue_load(off + 1, word[15:8]);
            queue_load(off + 2, word[23:16]);
            queue_load(off + 3, word[31:24]);
        end
    endfunction

    function automatic int unsigned hop_draw(int unsigned len);
        if ($urandom_range(0, 9) != 0) return $urandom_range(0, len + 2);
        return $urandom_range(0, 300);
    endfunction

    function automatic void build_chain();
        logic [CLU_W-1:0] nodes [$];
        logic [CLU_W-1:0] tail;
        int unsigned len, top, lo, hi, i, k;
        top = top_cluster();
        len = $urandom_range(1, 10);
        case ($urandom_range(0, 3))
            0, 1: begin
                lo = 0;
                hi = 65;
            end
            2: begin
                lo = top - 40;
                hi = top;
            end
            default: begin
                lo = 0;
                hi = top;
            end
        endcase
        for (i = 0; i < len; i++) nodes.push_back(CLU_W'($urandom_range(lo, hi)));
        for (i = 0; i + 1 < len; i++) set_link(nodes[i], nodes[i + 1]);
        case ($urandom_range(0, 4))
            0: tail = end_mark();
            1: tail = CLU_W'($urandom_range(end_mark(), entry_max()));
            2: tail = '0;
            3: tail = nodes[$urandom_range(0, len - 1)];
            default: tail = CLU_W'($urandom) & entry_max();
        endcase
        set_link(nodes[len - 1], tail);
        for (k = $urandom_range(1, 4); k > 0; k--) begin
            if ($urandom_range(0, 4) != 0)
                queue_walk(nodes[$urandom_range(0, len - 1)], HOP_W'(hop_draw(len)));
            else
                queue_walk(CLU_W'($urandom_range(0, top + 8)), HOP_W'(hop_draw(len)));
        end
    endfunction

    function automatic void fill_phase(int target);
        int n;
        phase_beats = 0;
        while (phase_beats < target) begin
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    for (n = $urandom_range(1, 4); n > 0; n--)
                        queue_load($urandom_range(0, TBL - 1), 8'($urandom));
                end
                3, 4: queue_walk(CLU_W'($urandom), HOP_W'($urandom_range(0, 5)));
                default: build_chain();
            endcase
        end
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic setup(logic [KIND_W-1:0] kind, logic [SPC_W-1:0] spc,
                         logic [FDS_W-1:0] fds, logic [PSTART_W-1:0] ps);
        logic [CFG_DATA_W-1:0] val;
        val = CFG_DATA_W'({$urandom, $urandom});
        val[KIND_W-1:0] = kind;
        write_reg(CFG_FAT_KIND, val);
        val = CFG_DATA_W'({$urandom, $urandom});
        val[SPC_W-1:0] = spc;
        write_reg(CFG_SPC, val);
        val = CFG_DATA_W'({$urandom, $urandom});
        val[FDS_W-1:0] = fds;
        write_reg(CFG_FIRST_DATA, val);
        write_reg(CFG_PART_START, ps);
        i_cfg_we <= 1'b0;
        cfg_kind = kind;
        cfg_spc = spc;
        cfg_fds = fds;
        cfg_ps = ps;
    endtask

    task automatic settle();
        while (beats_owed != 0 || chain_results_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // input side
    t_fat_beat cur_beat;
    bit        feed_took;
    bit        feed_next;
    bit        feed_burst = 1'b0;
    int        feed_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            feed_gap = 0;
        end else begin
            feed_took = push && !full;
            if (feed_took) begin
                if (cur_beat.op == OP_WALK)
                    chain_results_q.push_back(predict_walk(cur_beat.start, cur_beat.hops));
                else if (cur_beat.addr < TBL)
                    fat_mirror[cur_beat.addr] = cur_beat.data;
                beats_owed--;
                feed_gap = feed_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 39) == 0) feed_burst = !feed_burst;
            end
            feed_next = push && !feed_took;
            if (!feed_next) begin
                if (feed_gap != 0) begin
                    feed_gap--;
                end else if (table_ops_q.size() != 0) begin
                    cur_beat = table_ops_q.pop_front();
                    i_op <= cur_beat.op;
                    i_load_address <= cur_beat.addr;
                    i_load_byte <= cur_beat.data;
                    i_start_cluster <= cur_beat.start;
                    i_hop_count <= cur_beat.hops;
                    feed_next = 1'b1;
                end
            end
            push <= feed_next;
        end
    end

    // result side
    t_link_result want;
    bit           drain_burst = 1'b0;
    int           drain_wait = 0;
    int           hold_off = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            drain_wait = 0;
            hold_off = 0;
        end else begin
            if (pop && !empty) begin
                if (chain_results_q.size() == 0) begin
                    $display("%0t: unexpected beat, got cluster %h end %b sector %h",
                             $time, o_cluster, o_reached_end, o_sector_address);
                    fails++;
                end else begin
                    want = chain_results_q.pop_front();
                    if (o_cluster !== want.cluster) begin
                        $display("%0t: cluster expected %h, got %h",
                                 $time, want.cluster, o_cluster);
                        fails++;
                    end
                    if (o_reached_end !== want.end_hit) begin
                        $display("%0t: reached_end expected %b, got %b",
                                 $time, want.end_hit, o_reached_end);
                        fails++;
                    end
                    if (o_sector_address !== want.sector) begin
                        $display("%0t: sector_address expected %h, got %h",
                                 $time, want.sector, o_sector_address);
                        fails++;
                    end
                end
                results_seen++;
                drain_wait = drain_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 39) == 0) drain_burst = !drain_burst;
                if (results_seen == HOLD_AT) hold_off = HOLD_LEN;
            end else if (!pop) begin
                if (hold_off != 0) hold_off--;
                else if (drain_wait != 0) drain_wait--;
            end
            pop <= (hold_off == 0 && drain_wait == 0);
        end
    end

    initial begin
        int p;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: FAT16, one sector per cluster, zero bases
        queue_load(0, 8'h00);
        queue_load(TBL - 1, 8'hff);
        queue_walk(28'd0, 20'd0);
        queue_walk(28'd1, 20'd0);
        queue_walk({CLU_W{1'b1}}, 20'd0);
        queue_walk({CLU_W{1'b1}}, 20'd1);
        set_link(28'd2, 28'd3);
        set_link(28'd3, 28'd4);
        set_link(28'd4, EOC_FAT16);
        queue_walk(28'd2, {HOP_W{1'b1}});
        queue_walk(28'd2, 20'd0);
        queue_walk(28'd2, 20'd2);
        queue_walk(28'd2, 20'd3);
        set_link(28'd5, 28'd0);
        queue_walk(28'd5, 20'd1);
        set_link(28'd6, EOC_FAT16 - CLU_W'(1));
        queue_walk(28'd6, 20'd1);
        set_link(28'd7, 28'hffff);
        queue_walk(28'd7, 20'd1);
        set_link(28'(TBL / 2 - 1), 28'd2);
        queue_walk(28'(TBL / 2 - 1), 20'd3);
        fill_phase(100);

        for (p = 1; p < 8; p++) begin
            settle();
            case (p)
                1: setup(KIND_FAT12, 8'd128, '1, '1);
                2: setup(KIND_FAT32, 8'd0, '0, '0);
                3: setup(KIND_FAT32_ALT, 8'd255, $urandom, PSTART_W'({$urandom, $urandom}));
                default: setup(KIND_W'($urandom_range(0, 3)), SPC_W'($urandom_range(1, 128)),
                               $urandom, PSTART_W'({$urandom, $urandom}));
            endcase
            fill_phase(130);
        end
        settle();

        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
